// ----- hw/rtl/cmpl_pkg.sv -----
// Shared constants, vertex tables and helper functions for the cube mesh point locator.
package cmpl_pkg;

    // Width of each cells register and of a cell coordinate along one axis.
    localparam int CELL_W = 11;
    // Largest cell count that the cells registers can hold.
    localparam int CELL_MAX = (1 << CELL_W) - 1;
    // Width of the global element index.
    localparam int INDEX_W = 33;
    // Width of the partial index ex * cells_y + ey.
    localparam int ROW_W = 2 * CELL_W;

    localparam int NUM_TETS  = 5;
    localparam int NUM_FACES = 4;
    localparam int TET_W     = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_MODE = 2'd3;

    // Element modes.
    localparam logic MODE_HEX = 1'b0;
    localparam logic MODE_TET = 1'b1;

    // Unit-cube corners of the hexahedron vertices v0 to v7.
    localparam int CORNER [8][3] = '{
        '{0, 0, 0}, '{1, 0, 0}, '{1, 1, 0}, '{0, 1, 0},
        '{0, 0, 1}, '{1, 0, 1}, '{1, 1, 1}, '{0, 1, 1}
    };

    // Hexahedron vertices of each of the five tetrahedra.
    localparam int TET_MAP [NUM_TETS][4] = '{
        '{0, 1, 3, 4}, '{1, 2, 3, 6}, '{1, 3, 4, 6}, '{1, 4, 5, 6}, '{3, 4, 6, 7}
    };

    // Positions within a tetrahedron of the three vertices of each face.
    localparam int FACE_SEL [NUM_FACES][3] = '{
        '{0, 1, 2}, '{0, 3, 1}, '{1, 3, 2}, '{0, 2, 3}
    };

    // Coefficient of the signed volume of one face of one tetrahedron.
    // The volume is c0*x + c1*y + c2*z + c3*S, with S the coordinate scale;
    // k selects c0 to c3. Evaluated at elaboration only.
    function automatic int vol_coef(input int t, input int f, input int k);
        int ia;
        int ib;
        int ic;
        int r1 [3];
        int r2 [3];
        int n  [3];
        int res;
        ia = TET_MAP[t][FACE_SEL[f][0]];
        ib = TET_MAP[t][FACE_SEL[f][1]];
        ic = TET_MAP[t][FACE_SEL[f][2]];
        for (int i = 0; i < 3; i++)
        begin
            r1[i] = CORNER[ib][i] - CORNER[ia][i];
            r2[i] = CORNER[ic][i] - CORNER[ia][i];
        end
        n[0] = r1[1] * r2[2] - r1[2] * r2[1];
        n[1] = r1[2] * r2[0] - r1[0] * r2[2];
        n[2] = r1[0] * r2[1] - r1[1] * r2[0];
        if (k < 3)
        begin
            res = n[k];
        end
        else
        begin
            res = -(n[0] * CORNER[ia][0] + n[1] * CORNER[ia][1] + n[2] * CORNER[ia][2]);
        end
        return res;
    endfunction

    // A cell count of zero counts as one; counts above the limit are held at it.
    function automatic logic [CELL_W-1:0] clamp_cells(input logic [CELL_W-1:0] n,
                                                      input logic [CELL_W-1:0] lim);
        logic [CELL_W-1:0] res;
        res = n;
        if (n == '0)
        begin
            res = CELL_W'(1);
        end
        else if (n > lim)
        begin
            res = lim;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/cube_mesh_point_locate.sv -----
// Top level of the cube mesh point locator: configuration registers and the locate pipeline.

// Locates a Q0.COORD_FRAC_BITS point of the unit cube in a cells_x by cells_y by
// cells_z mesh of hexahedra, or of five tetrahedra per hexahedron when element_mode
// is 1, and returns found and the global cell index. The pipeline has four register
// stages: the per-axis cell multiply, the row index and the twenty face-volume sign
// tests, the final index multiply with the tetrahedron pick, and the output register.
// A request is taken every clock cycle while in_stall is low. A stalled output holds the
// result, and the stages behind it keep filling until every stage is occupied, only then
// is in_stall raised. The user must write the configuration registers only while the
// pipeline is empty; the block itself does not enforce it.
module cube_mesh_point_locate
    import cmpl_pkg::*;
#(
    parameter int MAX_CELLS_PER_SIDE = 1024,
    parameter int COORD_FRAC_BITS    = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration write port.
    input  logic                       cfg_write_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CELL_W-1:0]          cfg_data,
    // Request channel.
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [COORD_FRAC_BITS-1:0] point_x,
    input  logic [COORD_FRAC_BITS-1:0] point_y,
    input  logic [COORD_FRAC_BITS-1:0] point_z,
    // Result channel.
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       found,
    output logic [INDEX_W-1:0]         cell_index
);

    localparam int F       = COORD_FRAC_BITS;
    localparam int PROD_W  = F + CELL_W;
    localparam int VOL_W   = F + 5;
    localparam int MaxCnt  = (MAX_CELLS_PER_SIDE > CELL_MAX) ? CELL_MAX : MAX_CELLS_PER_SIDE;
    localparam logic [CELL_W-1:0] CELL_LIM = CELL_W'(MaxCnt);

    // Configuration registers.
    logic [CELL_W-1:0] cells_x_reg;
    logic [CELL_W-1:0] cells_y_reg;
    logic [CELL_W-1:0] cells_z_reg;
    logic              element_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg      <= CELL_W'(1);
            cells_y_reg      <= CELL_W'(1);
            cells_z_reg      <= CELL_W'(1);
            element_mode_reg <= MODE_HEX;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_CELLS_X:      cells_x_reg      <= cfg_data;
                CFG_CELLS_Y:      cells_y_reg      <= cfg_data;
                CFG_CELLS_Z:      cells_z_reg      <= cfg_data;
                CFG_ELEMENT_MODE: element_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Effective cell counts after clamping.
    logic [CELL_W-1:0] nx;
    logic [CELL_W-1:0] ny;
    logic [CELL_W-1:0] nz;

    assign nx = clamp_cells(cells_x_reg, CELL_LIM);
    assign ny = clamp_cells(cells_y_reg, CELL_LIM);
    assign nz = clamp_cells(cells_z_reg, CELL_LIM);

    // Stage valid bits and the enable chain; a stage moves when it is empty or
    // when the stage after it moves.
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic out_valid_reg;
    logic a_en;
    logic b_en;
    logic c_en;
    logic d_en;

    assign d_en     = !out_valid_reg || !out_stall;
    assign c_en     = !c_valid_reg || d_en;
    assign b_en     = !b_valid_reg || c_en;
    assign a_en     = !a_valid_reg || b_en;
    assign in_stall = !a_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_en)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_en)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    // Stage A: scale each coordinate by its cell count, split into cell and offset.
    logic [PROD_W-1:0] prod_x_next;
    logic [PROD_W-1:0] prod_y_next;
    logic [PROD_W-1:0] prod_z_next;
    logic [CELL_W-1:0] ex_reg;
    logic [CELL_W-1:0] ey_reg;
    logic [CELL_W-1:0] ez_reg;
    logic [F-1:0]      loc_x_reg;
    logic [F-1:0]      loc_y_reg;
    logic [F-1:0]      loc_z_reg;

    assign prod_x_next = PROD_W'(point_x) * PROD_W'(nx);
    assign prod_y_next = PROD_W'(point_y) * PROD_W'(ny);
    assign prod_z_next = PROD_W'(point_z) * PROD_W'(nz);

    always_ff @(posedge clk)
    begin
        if (a_en && in_valid)
        begin
            ex_reg    <= prod_x_next[PROD_W-1:F];
            ey_reg    <= prod_y_next[PROD_W-1:F];
            ez_reg    <= prod_z_next[PROD_W-1:F];
            loc_x_reg <= prod_x_next[F-1:0];
            loc_y_reg <= prod_y_next[F-1:0];
            loc_z_reg <= prod_z_next[F-1:0];
        end
    end

    // Stage B: row index ex * ny + ey, and the face-volume sign tests.
    logic signed [VOL_W-1:0]                  xs;
    logic signed [VOL_W-1:0]                  ys;
    logic signed [VOL_W-1:0]                  zs;
    logic [NUM_TETS-1:0][NUM_FACES-1:0]       face_ok;
    logic [NUM_TETS-1:0]                      tet_ok_next;
    logic [ROW_W-1:0]                         row_next;
    logic [ROW_W-1:0]                         row_reg;
    logic [CELL_W-1:0]                        ez_b_reg;
    logic [NUM_TETS-1:0]                      tet_ok_reg;

    assign xs = $signed({5'b0, loc_x_reg});
    assign ys = $signed({5'b0, loc_y_reg});
    assign zs = $signed({5'b0, loc_z_reg});

    for (genvar t = 0; t < NUM_TETS; t++)
    begin : gen_tet
        for (genvar f = 0; f < NUM_FACES; f++)
        begin : gen_face
            localparam logic signed [VOL_W-1:0] K0 = VOL_W'(vol_coef(t, f, 0));
            localparam logic signed [VOL_W-1:0] K1 = VOL_W'(vol_coef(t, f, 1));
            localparam logic signed [VOL_W-1:0] K2 = VOL_W'(vol_coef(t, f, 2));
            localparam logic signed [VOL_W-1:0] K3 =
                VOL_W'(longint'(vol_coef(t, f, 3)) * (longint'(1) <<< F));
            logic signed [VOL_W-1:0] vol;

            assign vol = K0 * xs + K1 * ys + K2 * zs + K3;
            assign face_ok[t][f] = !vol[VOL_W-1];
        end
        assign tet_ok_next[t] = &face_ok[t];
    end

    assign row_next = ROW_W'(ROW_W'(ex_reg) * ROW_W'(ny)) + ROW_W'(ey_reg);

    always_ff @(posedge clk)
    begin
        if (b_en && a_valid_reg)
        begin
            row_reg    <= row_next;
            ez_b_reg   <= ez_reg;
            tet_ok_reg <= tet_ok_next;
        end
    end

    // Stage C: hexahedron index and the lowest tetrahedron that holds the point.
    logic [INDEX_W-1:0] hex_next;
    logic [INDEX_W-1:0] hex_reg;
    logic               tet_hit_next;
    logic [TET_W-1:0]   tet_num_next;
    logic               tet_hit_reg;
    logic [TET_W-1:0]   tet_num_reg;

    assign hex_next = INDEX_W'(INDEX_W'(row_reg) * INDEX_W'(nz)) + INDEX_W'(ez_b_reg);

    always_comb
    begin
        tet_hit_next = 1'b0;
        tet_num_next = '0;
        for (int i = NUM_TETS - 1; i >= 0; i--)
        begin
            if (tet_ok_reg[i])
            begin
                tet_hit_next = 1'b1;
                tet_num_next = TET_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_en && b_valid_reg)
        begin
            hex_reg     <= hex_next;
            tet_hit_reg <= tet_hit_next;
            tet_num_reg <= tet_num_next;
        end
    end

    // Stage D: final index in the chosen mode, held in the output register.
    logic [INDEX_W+1:0] tet_index;
    logic               found_next;
    logic [INDEX_W-1:0] cell_index_next;
    logic               found_reg;
    logic [INDEX_W-1:0] cell_index_reg;

    assign tet_index = {hex_reg, 2'b00} + {2'b00, hex_reg} + (INDEX_W + 2)'(tet_num_reg);

    always_comb
    begin
        priority if (element_mode_reg == MODE_HEX)
        begin
            found_next      = 1'b1;
            cell_index_next = hex_reg;
        end
        else if (tet_hit_reg)
        begin
            found_next      = 1'b1;
            cell_index_next = tet_index[INDEX_W-1:0];
        end
        else
        begin
            found_next      = 1'b0;
            cell_index_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_en && c_valid_reg)
        begin
            found_reg      <= found_next;
            cell_index_reg <= cell_index_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign cell_index = cell_index_reg;

`ifndef ASSERT_OFF
    // A cell coordinate always lies below its cell count.
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (ex_reg < nx) && (ey_reg < ny) && (ez_reg < nz))
        else $error("cell coordinate out of range");

    // The input side stalls only when every stage is full and the output is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> a_valid_reg && b_valid_reg && c_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    // A full stage B whose successor cannot move keeps its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !c_en |=> b_valid_reg && $stable(row_reg) && $stable(tet_ok_reg))
        else $error("stalled stage lost its request");

    // A miss carries index zero, and hexahedron mode always finds a cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> cell_index_reg == '0 && element_mode_reg == MODE_TET)
        else $error("bad result for a missed point");
`endif

endmodule
